// File: design/dmt_pkg.sv
// dmt_pkg: shared types and constants for the disjoint mask triad search block
// no dependencies; imported by dmt_ctrl, dmt_dpath and the top level
`timescale 1ns / 1ps

package dmt_pkg;

  localparam int FUNC_W      = 2;
  localparam int MASK_W      = 36;
  localparam int IN_TDATA_W  = 40;
  localparam int IDX_W       = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (3 * IDX_W + 2);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_t;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_a;
    logic             rd_b0;
    logic             rd_b1;
    logic             capture;
    logic             found;
    logic             ovf;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ab_hit;
    logic abc_hit;
  } sts_t;

endpackage

// File: design/dmt_dpath.sv
// dmt_dpath: list memories, registered read data, overlap checks, result register
// depends on dmt_pkg; driven by dmt_ctrl commands
`timescale 1ns / 1ps

module dmt_dpath #(
  parameter int LIST_A_DEPTH = 256,
  parameter int LIST_B_DEPTH = 256,
  parameter int EDGE_BITS    = 36,
  localparam int ADDR_A_W    = (LIST_A_DEPTH > 1) ? $clog2(LIST_A_DEPTH) : 1,
  localparam int ADDR_B_W    = (LIST_B_DEPTH > 1) ? $clog2(LIST_B_DEPTH) : 1
) (
  input  logic                            clk,
  input  dmt_pkg::cmd_t                   cmd,
  input  logic [dmt_pkg::MASK_W-1:0]      in_mask,
  input  logic [ADDR_A_W-1:0]             wr_a_addr,
  input  logic [ADDR_B_W-1:0]             wr_b_addr,
  input  logic [ADDR_A_W-1:0]             rd_a_addr,
  input  logic [ADDR_B_W-1:0]             rd_b0_addr,
  input  logic [ADDR_B_W-1:0]             rd_b1_addr,
  output dmt_pkg::sts_t                   sts,
  output logic [dmt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dmt_pkg::*;

  logic [EDGE_BITS-1:0]   mem_a [LIST_A_DEPTH];
  logic [EDGE_BITS-1:0]   mem_b [LIST_B_DEPTH];
  logic [EDGE_BITS-1:0]   wr_mask;
  logic [EDGE_BITS-1:0]   a_rd_r;
  logic [EDGE_BITS-1:0]   b0_rd_r;
  logic [EDGE_BITS-1:0]   b1_rd_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign wr_mask = EDGE_BITS'(in_mask);

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_a_addr] <= wr_mask;
    end
    if (cmd.rd_a) begin
      a_rd_r <= mem_a[rd_a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[wr_b_addr] <= wr_mask;
    end
    if (cmd.rd_b0) begin
      b0_rd_r <= mem_b[rd_b0_addr];
    end
    if (cmd.rd_b1) begin
      b1_rd_r <= mem_b[rd_b1_addr];
    end
  end

  assign sts.ab_hit  = |(a_rd_r & b0_rd_r);
  assign sts.abc_hit = |((a_rd_r | b0_rd_r) & b1_rd_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, cmd.ovf, cmd.idx_c, cmd.idx_b, cmd.idx_a, cmd.found};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

// File: design/dmt_ctrl.sv
// dmt_ctrl: list counters, overflow flag and search sequencer
// depends on dmt_pkg; commands dmt_dpath
`timescale 1ns / 1ps

module dmt_ctrl #(
  parameter int LIST_A_DEPTH = 256,
  parameter int LIST_B_DEPTH = 256,
  localparam int ADDR_A_W    = (LIST_A_DEPTH > 1) ? $clog2(LIST_A_DEPTH) : 1,
  localparam int ADDR_B_W    = (LIST_B_DEPTH > 1) ? $clog2(LIST_B_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dmt_pkg::FUNC_W-1:0] in_func,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  dmt_pkg::sts_t              sts,
  output dmt_pkg::cmd_t              cmd,
  output logic [ADDR_A_W-1:0]        wr_a_addr,
  output logic [ADDR_B_W-1:0]        wr_b_addr,
  output logic [ADDR_A_W-1:0]        rd_a_addr,
  output logic [ADDR_B_W-1:0]        rd_b0_addr,
  output logic [ADDR_B_W-1:0]        rd_b1_addr
);
  import dmt_pkg::*;

  localparam int CNT_A_W = $clog2(LIST_A_DEPTH + 1);
  localparam int CNT_B_W = $clog2(LIST_B_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_A,
    S_B,
    S_BCHK,
    S_C,
    S_CCHK,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_A_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_B_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [CNT_A_W-1:0] ia_r, ia_nxt;
  logic [CNT_B_W-1:0] ib_r, ib_nxt;
  logic [CNT_B_W-1:0] ic_r, ic_nxt;
  logic               ovf_r, ovf_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign wr_a_addr  = cnt_a_r[ADDR_A_W-1:0];
  assign wr_b_addr  = cnt_b_r[ADDR_B_W-1:0];
  assign rd_a_addr  = ia_r[ADDR_A_W-1:0];
  assign rd_b0_addr = ib_r[ADDR_B_W-1:0];
  assign rd_b1_addr = ic_r[ADDR_B_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    ic_nxt        = ic_r;
    ovf_nxt       = ovf_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.found     = found_r;
    cmd.ovf       = ovf_r;
    cmd.idx_a     = found_r ? IDX_W'(ia_r) : '0;
    cmd.idx_b     = found_r ? IDX_W'(ib_r) : '0;
    cmd.idx_c     = found_r ? IDX_W'(ic_r) : '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_func)
            FUNC_LOAD_A: begin
              if (cnt_a_r != CNT_A_W'(LIST_A_DEPTH)) begin
                cmd.wr_a  = 1'b1;
                cnt_a_nxt = cnt_a_r + CNT_A_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            FUNC_LOAD_B: begin
              if (cnt_b_r != CNT_B_W'(LIST_B_DEPTH)) begin
                cmd.wr_b  = 1'b1;
                cnt_b_nxt = cnt_b_r + CNT_B_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            FUNC_SEARCH: begin
              ia_nxt    = '0;
              found_nxt = 1'b0;
              state_nxt = S_A;
            end
            default: begin
            end
          endcase
        end
      end
      S_A: begin
        if (ia_r == cnt_a_r) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_a  = 1'b1;
          ib_nxt    = '0;
          state_nxt = S_B;
        end
      end
      S_B: begin
        if (ib_r == cnt_b_r) begin
          ia_nxt    = ia_r + CNT_A_W'(1);
          state_nxt = S_A;
        end else begin
          cmd.rd_b0 = 1'b1;
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (sts.ab_hit) begin
          ib_nxt    = ib_r + CNT_B_W'(1);
          state_nxt = S_B;
        end else begin
          ic_nxt    = ib_r + CNT_B_W'(1);
          state_nxt = S_C;
        end
      end
      S_C: begin
        if (ic_r == cnt_b_r) begin
          ib_nxt    = ib_r + CNT_B_W'(1);
          state_nxt = S_B;
        end else begin
          cmd.rd_b1 = 1'b1;
          state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        if (!sts.abc_hit) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          ic_nxt    = ic_r + CNT_B_W'(1);
          state_nxt = S_C;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          cnt_a_nxt     = '0;
          cnt_b_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      ic_r        <= '0;
      ovf_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      ic_r        <= ic_nxt;
      ovf_r       <= ovf_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/disjoint_mask_triad_two_lists_top.sv
// channel  | dir | ports                         | carries
// in       | in  | in_tvalid/tready/tdata/tuser  | tuser: func; tdata: mask
// out      | out | out_tvalid/tready/tdata       | tdata: found, index a/b/c, overflow
//
// a load item is taken while idle; func 3 is taken and dropped with no result
// a search walks the lists for each visited a, b and c position (address, then registered
// read data and check), closes each c scan and the a list, and then hands the result to
// the output register
// no item is taken from issue of a search until its result is in the output register
// loads are taken while an earlier result waits; a search result waits for the output register
// reset (rst_n low, synchronous) empties both lists and clears the overflow flag
// top level: joins dmt_ctrl and dmt_dpath; depends on dmt_pkg
`timescale 1ns / 1ps

module disjoint_mask_triad_two_lists_top #(
  parameter int LIST_A_DEPTH = 256,
  parameter int LIST_B_DEPTH = 256,
  parameter int EDGE_BITS    = 36
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [35:0] mask, [39:36] zero
  input  logic [dmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [dmt_pkg::FUNC_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] triad_found, [8:1] index_a, [16:9] index_b, [24:17] index_c,
  // [25] load_overflow, [31:26] zero
  output logic [dmt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dmt_pkg::*;

  localparam int ADDR_A_W = (LIST_A_DEPTH > 1) ? $clog2(LIST_A_DEPTH) : 1;
  localparam int ADDR_B_W = (LIST_B_DEPTH > 1) ? $clog2(LIST_B_DEPTH) : 1;

  cmd_t                cmd;
  sts_t                sts;
  logic [ADDR_A_W-1:0] wr_a_addr;
  logic [ADDR_B_W-1:0] wr_b_addr;
  logic [ADDR_A_W-1:0] rd_a_addr;
  logic [ADDR_B_W-1:0] rd_b0_addr;
  logic [ADDR_B_W-1:0] rd_b1_addr;

  dmt_ctrl #(
    .LIST_A_DEPTH (LIST_A_DEPTH),
    .LIST_B_DEPTH (LIST_B_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .wr_a_addr  (wr_a_addr),
    .wr_b_addr  (wr_b_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b0_addr (rd_b0_addr),
    .rd_b1_addr (rd_b1_addr)
  );

  dmt_dpath #(
    .LIST_A_DEPTH (LIST_A_DEPTH),
    .LIST_B_DEPTH (LIST_B_DEPTH),
    .EDGE_BITS    (EDGE_BITS)
  ) u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .in_mask    (in_tdata[MASK_W-1:0]),
    .wr_a_addr  (wr_a_addr),
    .wr_b_addr  (wr_b_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b0_addr (rd_b0_addr),
    .rd_b1_addr (rd_b1_addr),
    .sts        (sts),
    .out_tdata  (out_tdata)
  );

  // list writes only happen on an accepted load
  a_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_a || cmd.wr_b) |-> (in_tvalid && in_tready))
    else $error("list write without accepted item");

  // memory reads only happen while a search runs
  a_rd_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_a || cmd.rd_b0 || cmd.rd_b1) |-> !in_tready)
    else $error("list read outside search");

  // capture loads the output register
  a_capture_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_tvalid)
    else $error("captured result not presented");

  // a miss reports all indices as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[24:1] == 24'd0))
    else $error("miss with nonzero index");

  // a hit has its second b position above the first
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0] && (LIST_B_DEPTH <= 256)) |->
      (out_tdata[24:17] > out_tdata[16:9]))
    else $error("index_c not above index_b");

endmodule

// File: tb/sv/tb_disjoint_mask_triad_two_lists_top.sv
`timescale 1ns / 1ps
// tb_disjoint_mask_triad_two_lists_top: self-checking bench for the disjoint mask triad search
// predicts every search result from its own copy of both lists and checks each output item
// depends on dmt_pkg and disjoint_mask_triad_two_lists_top

module tb_disjoint_mask_triad_two_lists_top;
  import dmt_pkg::*;

  localparam int A_DEPTH = 256;
  localparam int B_DEPTH = 256;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [MASK_W-1:0] ALL_ONES = '1;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [MASK_W-1:0] mask;
  } item_t;

  typedef struct {
    logic             found;
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic             ovf;
  } triad_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  item_t  pending_q[$];
  triad_t triad_q[$];
  int     n_queued = 0;
  int     n_taken = 0;
  int     n_bad = 0;
  int     snd_idle_pct = 0;
  int     rcv_stall_pct = 0;
  logic   hold_arm = 1'b0;
  logic   hold_done = 1'b0;
  int     hold_cnt = 0;

  logic [MASK_W-1:0] list_a[A_DEPTH];
  logic [MASK_W-1:0] list_b[B_DEPTH];
  int                cnt_a = 0;
  int                cnt_b = 0;
  logic              ovf_seen = 1'b0;

  disjoint_mask_triad_two_lists_top #(
    .LIST_A_DEPTH(A_DEPTH),
    .LIST_B_DEPTH(B_DEPTH),
    .EDGE_BITS(MASK_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // list update and triad search for one accepted item
  task automatic apply_item(input logic [FUNC_W-1:0] func, input logic [MASK_W-1:0] mask);
    triad_t           r;
    logic [MASK_W-1:0] acc2;
    r = '{found: 1'b0, ia: '0, ib: '0, ic: '0, ovf: 1'b0};
    case (func)
      FUNC_LOAD_A: begin
        if (cnt_a < A_DEPTH) begin
          list_a[cnt_a] = mask;
          cnt_a++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      FUNC_LOAD_B: begin
        if (cnt_b < B_DEPTH) begin
          list_b[cnt_b] = mask;
          cnt_b++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      FUNC_SEARCH: begin
        for (int a = 0; a < cnt_a && !r.found; a++) begin
          for (int b = 0; b < cnt_b && !r.found; b++) begin
            if ((list_a[a] & list_b[b]) == '0) begin
              acc2 = list_a[a] | list_b[b];
              for (int c = b + 1; c < cnt_b && !r.found; c++) begin
                if ((acc2 & list_b[c]) == '0) begin
                  r.found = 1'b1;
                  r.ia = IDX_W'(a);
                  r.ib = IDX_W'(b);
                  r.ic = IDX_W'(c);
                end
              end
            end
          end
        end
        r.ovf = ovf_seen;
        triad_q.push_back(r);
        cnt_a = 0;
        cnt_b = 0;
        ovf_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_item(in_tuser, in_tdata[MASK_W-1:0]);
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          it = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= it.func;
          in_tdata  <= {{(IN_TDATA_W - MASK_W){1'b0}}, it.mask};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done  <= 1'b1;
      hold_cnt   <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    triad_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (triad_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result item: tdata=%h", out_tdata);
      end else begin
        e = triad_q.pop_front();
        if (out_tdata[0] !== e.found || out_tdata[8:1] !== e.ia || out_tdata[16:9] !== e.ib
            || out_tdata[24:17] !== e.ic || out_tdata[25] !== e.ovf) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("result mismatch: exp found=%0d a=%0d b=%0d c=%0d ovf=%0d",
                     e.found, e.ia, e.ib, e.ic, e.ovf);
            $display("                 got found=%0d a=%0d b=%0d c=%0d ovf=%0d",
                     out_tdata[0], out_tdata[8:1], out_tdata[16:9], out_tdata[24:17],
                     out_tdata[25]);
          end
        end
      end
    end
  end

  task automatic push_item(input logic [FUNC_W-1:0] func, input logic [MASK_W-1:0] mask);
    item_t it;
    it.func = func;
    it.mask = mask;
    pending_q.push_back(it);
    n_queued++;
  endtask

  function automatic logic [MASK_W-1:0] rand_mask();
    logic [63:0] r1;
    logic [63:0] r2;
    logic [63:0] r3;
    r1 = {$urandom, $urandom};
    r2 = {$urandom, $urandom};
    r3 = {$urandom, $urandom};
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      2: return MASK_W'(64'd1 << $urandom_range(MASK_W - 1));
      3: return r1[MASK_W-1:0];
      4, 5: return r1[MASK_W-1:0] & r2[MASK_W-1:0];
      default: return r1[MASK_W-1:0] & r2[MASK_W-1:0] & r3[MASK_W-1:0];
    endcase
  endfunction

  // mostly load runs closed by a search, sometimes stray items
  task automatic add_group(output int n);
    int na;
    int nb;
    n = 0;
    if ($urandom_range(99) < 85) begin
      na = $urandom_range(5);
      nb = $urandom_range(7);
      while (na + nb > 0) begin
        if (nb == 0 || (na > 0 && $urandom_range(1) == 1)) begin
          push_item(FUNC_LOAD_A, rand_mask());
          na--;
        end else begin
          push_item(FUNC_LOAD_B, rand_mask());
          nb--;
        end
        n++;
      end
      push_item(FUNC_SEARCH, rand_mask());
      n++;
    end else begin
      case ($urandom_range(3))
        0: push_item(FUNC_UNUSED, rand_mask());
        1: begin
          push_item(FUNC_SEARCH, rand_mask());
          n++;
        end
        2: begin
          push_item($urandom_range(1) ? FUNC_LOAD_B : FUNC_LOAD_A, rand_mask());
          n++;
        end
        default: begin
          push_item(FUNC_UNUSED, rand_mask());
          push_item(FUNC_LOAD_A, rand_mask());
          n++;
        end
      endcase
    end
  endtask

  task automatic drain();
    while (n_taken != n_queued || triad_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    int n_phase;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty lists, unused selector, simple hits and misses
    push_item(FUNC_SEARCH, '0);
    push_item(FUNC_UNUSED, ALL_ONES);
    push_item(FUNC_LOAD_A, '0);
    push_item(FUNC_LOAD_B, ALL_ONES);
    push_item(FUNC_LOAD_B, 36'h1);
    push_item(FUNC_LOAD_B, 36'h2);
    push_item(FUNC_SEARCH, ALL_ONES);
    push_item(FUNC_LOAD_A, ALL_ONES);
    push_item(FUNC_LOAD_B, 36'h1);
    push_item(FUNC_LOAD_B, 36'h2);
    push_item(FUNC_SEARCH, '0);
    push_item(FUNC_LOAD_A, ALL_ONES);
    push_item(FUNC_LOAD_A, 36'h800000000);
    push_item(FUNC_LOAD_B, 36'h1);
    push_item(FUNC_LOAD_B, 36'h2);
    push_item(FUNC_LOAD_B, 36'h4);
    push_item(FUNC_SEARCH, '0);
    push_item(FUNC_LOAD_A, '0);
    push_item(FUNC_LOAD_B, '0);
    push_item(FUNC_SEARCH, '0);
    push_item(FUNC_LOAD_A, 36'h555555555);
    push_item(FUNC_LOAD_B, 36'hAAAAAAAAA);
    push_item(FUNC_LOAD_B, '0);
    push_item(FUNC_SEARCH, '0);
    drain();

    // both lists full with one dropped load each, hit at positions above 127,
    // then a search on the emptied lists
    repeat (200) push_item(FUNC_LOAD_A, ALL_ONES);
    push_item(FUNC_LOAD_A, '0);
    repeat (A_DEPTH - 200) push_item(FUNC_LOAD_A, ALL_ONES);
    repeat (150) push_item(FUNC_LOAD_B, ALL_ONES);
    push_item(FUNC_LOAD_B, 36'h1);
    push_item(FUNC_LOAD_B, 36'h2);
    repeat (B_DEPTH - 151) push_item(FUNC_LOAD_B, rand_mask() | 36'h1);
    push_item(FUNC_SEARCH, '0);
    push_item(FUNC_SEARCH, '0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct  <= 0;
          rcv_stall_pct <= 0;
          hold_arm      <= 1'b1;
        end
        1: begin
          snd_idle_pct  <= 45;
          rcv_stall_pct <= 0;
        end
        2: begin
          snd_idle_pct  <= 0;
          rcv_stall_pct <= 45;
        end
        default: begin
          snd_idle_pct  <= 20;
          rcv_stall_pct <= 20;
        end
      endcase
      n_phase = 0;
      while (n_phase < 30) begin
        add_group(n);
        n_phase += n;
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (n_bad == 0 && triad_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
